@@ rtl/core/pgs_pkg.sv @@
package pgs_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CNT_FIELD_W = 6;
    localparam int PAT_W       = 32;
    localparam int FIRST_W     = 16;
    localparam int GAP_MS      = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PULSE  = 2'd2;

    // lowest bit first on the bus: trigger_out, reset_lamp, step_position, unmask_progress
    typedef struct packed {
        logic [CNT_FIELD_W-1:0] unmask_progress;
        logic [CNT_FIELD_W-1:0] step_position;
        logic                   reset_lamp;
        logic                   trigger_out;
    } pgs_result_t;

    localparam int RESULT_W = $bits(pgs_result_t);

endpackage

@@ rtl/core/pgs_core.sv @@
module pgs_core #(
    parameter int MAX_STEPS = 32,
    parameter int TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pgs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                item_accept,
    input  logic                                gate_level,
    output pgs_pkg::pgs_result_t                result
);
    import pgs_pkg::*;

    localparam int IW = $clog2(MAX_STEPS + 1);
    localparam int MW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [CNT_FIELD_W-1:0] step_count_reg;
    logic [PAT_W-1:0]       step_pattern_reg;

    logic [IW-1:0]          step_index_reg, step_index_next;
    logic [IW-1:0]          unmask_count_reg, unmask_count_next;
    logic [MAX_STEPS-1:0]   unmask_bits_reg, unmask_bits_next;
    logic                   gate_seen_reg, gate_seen_next;
    logic                   fire_hold_reg, fire_hold_next;
    logic [TIME_BITS-1:0]   gate_width_reg, gate_width_next;
    logic [TIME_BITS-1:0]   pulse_length_reg, pulse_length_next;
    logic                   pulse_active_reg, pulse_active_next;
    logic [TIME_BITS-1:0]   pulse_remaining_reg, pulse_remaining_next;

    logic [IW-1:0]          active_len;
    logic [IW:0]            count_inc;
    logic [TIME_BITS:0]     width_sum;
    logic                   lamp;
    logic                   pat_bit;
    logic                   opn_bit;

    always_comb
    begin
        if (step_count_reg == '0)
            active_len = IW'(1);
        else if (32'(step_count_reg) > 32'(MAX_STEPS))
            active_len = IW'(MAX_STEPS);
        else
            active_len = IW'(step_count_reg);
    end

    always_comb
    begin
        step_index_next      = step_index_reg;
        unmask_count_next    = unmask_count_reg;
        unmask_bits_next     = unmask_bits_reg;
        gate_seen_next       = gate_seen_reg;
        fire_hold_next       = fire_hold_reg;
        gate_width_next      = gate_width_reg;
        pulse_length_next    = pulse_length_reg;
        pulse_active_next    = pulse_active_reg;
        pulse_remaining_next = pulse_remaining_reg;
        lamp                 = 1'b0;
        count_inc            = '0;
        width_sum            = '0;
        pat_bit              = 1'b0;
        opn_bit              = 1'b0;

        // lamp countdown from the previous tick's state
        if (pulse_active_reg)
        begin
            if (pulse_remaining_reg == '0)
                pulse_active_next = 1'b0;
            else
            begin
                pulse_remaining_next = pulse_remaining_reg - 1'b1;
                lamp = 1'b1;
            end
        end

        if (gate_seen_reg && gate_width_reg != TIME_MAX)
            gate_width_next = gate_width_reg + 1'b1;

        if (gate_level)
        begin
            if (!gate_seen_reg)
            begin
                gate_seen_next  = 1'b1;
                gate_width_next = '0;
                if (step_index_reg >= active_len)
                begin
                    step_index_next = '0;
                    if (unmask_count_reg < active_len)
                        unmask_bits_next[unmask_count_reg[MW-1:0]] = 1'b1;
                    count_inc = {1'b0, unmask_count_reg} + 1'b1;
                    if (count_inc > {1'b0, active_len})
                    begin
                        // every step opened: clear and start the lamp pulse
                        unmask_count_next    = '0;
                        unmask_bits_next     = '0;
                        pulse_active_next    = 1'b1;
                        pulse_remaining_next = pulse_length_reg;
                    end
                    else
                        unmask_count_next = count_inc[IW-1:0];
                end
                pat_bit = (32'(step_index_next) < 32) && step_pattern_reg[5'(step_index_next)];
                opn_bit = unmask_bits_next[step_index_next[MW-1:0]];
                fire_hold_next  = pat_bit && opn_bit;
                step_index_next = step_index_next + 1'b1;
            end
        end
        else
        begin
            if (gate_seen_reg)
            begin
                width_sum = {1'b0, gate_width_next} + (TIME_BITS+1)'(GAP_MS);
                pulse_length_next = width_sum[TIME_BITS] ? TIME_MAX : width_sum[TIME_BITS-1:0];
            end
            gate_seen_next = 1'b0;
            fire_hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg      <= CNT_FIELD_W'(8);
            step_pattern_reg    <= PAT_W'(1);
            step_index_reg      <= '0;
            unmask_count_reg    <= '0;
            unmask_bits_reg     <= '0;
            gate_seen_reg       <= 1'b0;
            fire_hold_reg       <= 1'b0;
            gate_width_reg      <= '0;
            pulse_length_reg    <= '0;
            pulse_active_reg    <= 1'b0;
            pulse_remaining_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_COUNT:   step_count_reg   <= cfg_data[CNT_FIELD_W-1:0];
                CFG_STEP_PATTERN: step_pattern_reg <= cfg_data[PAT_W-1:0];
                CFG_FIRST_PULSE:
                begin
                    if (TIME_BITS >= FIRST_W)
                        pulse_length_reg <= TIME_BITS'(cfg_data[FIRST_W-1:0]);
                    else
                        pulse_length_reg <= cfg_data[TIME_BITS-1:0];
                end
                default: ;
            endcase
        end
        else if (item_accept)
        begin
            step_index_reg      <= step_index_next;
            unmask_count_reg    <= unmask_count_next;
            unmask_bits_reg     <= unmask_bits_next;
            gate_seen_reg       <= gate_seen_next;
            fire_hold_reg       <= fire_hold_next;
            gate_width_reg      <= gate_width_next;
            pulse_length_reg    <= pulse_length_next;
            pulse_active_reg    <= pulse_active_next;
            pulse_remaining_reg <= pulse_remaining_next;
        end
    end

    always_comb
    begin
        result.trigger_out     = fire_hold_next;
        result.reset_lamp      = lamp;
        result.step_position   = CNT_FIELD_W'(step_index_next);
        result.unmask_progress = CNT_FIELD_W'(unmask_count_next);
    end

endmodule

@@ rtl/core/pgs_out_buf.sv @@
module pgs_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pgs_pkg::pgs_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pgs_pkg::pgs_result_t out_data
);
    import pgs_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    pgs_result_t main_data_reg;
    pgs_result_t skid_data_reg;
    logic        take;
    logic        push;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign take      = main_valid_reg && out_ready;
    assign push      = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (take)
                    skid_valid_reg <= 1'b0;
            end
            else if (push && main_valid_reg && !take)
                skid_valid_reg <= 1'b1;

            if (skid_valid_reg)
                main_valid_reg <= 1'b1;
            else if (push)
                main_valid_reg <= 1'b1;
            else if (take)
                main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                main_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            // park the item while the output is stalled
            if (main_valid_reg && !take)
                skid_data_reg <= in_data;
            else
                main_data_reg <= in_data;
        end
    end

endmodule

@@ rtl/core/phasing_gate_sequencer.sv @@
// Each accepted item's result is registered in the output buffer for the m_ side.
// Throughput: one item per cycle while the skid entry is free; the whole state
// update is a single combinational pass into the state registers and the output
// register. A two-entry output buffer keeps input flowing for one item of stall.
// Reset (rst_n low, asynchronous): counters, mask and lamp clear, step_count 8,
// step_pattern 1, pulse length 0; no item is held.
module phasing_gate_sequencer #(
    parameter int MAX_STEPS = 32,
    parameter int TIME_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [0] gate_level
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] trigger_out, [1] reset_lamp, [7:2] step_position, [13:8] unmask_progress
    output logic [15:0]                    m_tdata
);
    import pgs_pkg::*;

    pgs_result_t core_result;
    pgs_result_t out_result;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    pgs_core #(
        .MAX_STEPS (MAX_STEPS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (accept),
        .gate_level  (s_tdata[0]),
        .result      (core_result)
    );

    pgs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(16 - RESULT_W)'(0), out_result};

endmodule
